// ----- hw/rtl/bilist_pkg.sv -----
package bilist_pkg;

  // Command codes carried on cmd_i.
  localparam logic [2:0] CMD_INSERT_AT   = 3'd0;
  localparam logic [2:0] CMD_APPEND      = 3'd1;
  localparam logic [2:0] CMD_REMOVE_AT   = 3'd2;
  localparam logic [2:0] CMD_REMOVE_LAST = 3'd3;
  localparam logic [2:0] CMD_READ_AT     = 3'd4;
  localparam logic [2:0] CMD_READ_LAST   = 3'd5;
  localparam logic [2:0] CMD_CLEAR       = 3'd6;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_IDX = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Register index of the capacity limit in the configuration space.
  localparam logic REG_CAP_LIMIT = 1'b0;

  // Fixed payload widths.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LIMIT_W = 7;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  // Control broadcast from the sequencer to the row of cells.
  typedef struct packed {
    cell_op_e                  op;
    logic                      rd_en;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/bilist_cell.sv -----
module bilist_cell #(
  parameter int unsigned IDX_W = 7,
  parameter int unsigned INDEX = 0
) (
  input  logic                              clk_i,
  input  bilist_pkg::cell_ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0]                  pos_i,
  input  logic [IDX_W-1:0]                  hi_i,
  input  logic [IDX_W-1:0]                  rd_idx_i,
  input  logic signed [bilist_pkg::DATA_W-1:0] left_i,
  input  logic signed [bilist_pkg::DATA_W-1:0] right_i,
  output logic signed [bilist_pkg::DATA_W-1:0] data_o,
  output logic signed [bilist_pkg::DATA_W-1:0] tap_o
);
  import bilist_pkg::*;

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  logic signed [DATA_W-1:0] data_d, data_q;

  // Insert loads the new value at the position and pulls from the left above it;
  // remove pulls from the right from the position up to the entry below hi_i.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (IDX == pos_i) begin
          data_d = ctrl_i.value;
        end else if ((IDX > pos_i) && (IDX <= hi_i)) begin
          data_d = left_i;
        end
      end
      OP_REMOVE: begin
        if ((IDX >= pos_i) && (IDX < hi_i)) begin
          data_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry storage; its contents are only meaningful below the count.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // The selected cell drives its entry onto the read tap, others drive zero.
  assign tap_o = (ctrl_i.rd_en && (rd_idx_i == IDX)) ? data_q : '0;

endmodule

// ----- hw/rtl/bounded_insert_remove_list_core.sv -----
// Bounded ordered list held in a row of shifting cells.
// Results: a command accepted at a clock edge gives its result, with done_o high,
// in the following cycle.
// Throughput: one command per cycle; busy_o stays low since the whole row of cells shifts at once.
// Reset: the count clears to zero, the capacity limit returns to 64, done_o is low.
// Results are strobed for exactly one cycle; the receiver cannot stall them.
module bounded_insert_remove_list_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  cmd_i,
  input  logic [5:0]  position_i,
  input  logic signed [31:0] value_i,
  // Result channel
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]  count_o,
  output logic        is_full_o,
  output logic        is_empty_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bilist_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);

  // Configuration register
  logic [LIMIT_W-1:0] cap_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAP_LIMIT);
  assign prdata = (paddr[2] == REG_CAP_LIMIT) ? {{(32-LIMIT_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= LIMIT_W'(64);
    end else if (cfg_wr) begin
      cap_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Effective limit: zero reads as one, anything above the store size is clipped.
  logic [WW-1:0] cap_w, lim;
  assign cap_w = WW'(cap_q);
  assign lim   = (cap_q == '0) ? WW'(1) : ((cap_w > CAP_W) ? CAP_W : cap_w);

  // Command decode
  logic             accept;
  logic [CW-1:0]    cnt_q, cnt_d, cnt_m1;
  logic [WW-1:0]    cnt_w, pos_w;
  logic             full_now;
  cell_ctrl_t       ctrl;
  logic [CW-1:0]    cell_pos, cell_hi, rd_idx;
  logic [1:0]       status_d;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign cnt_w    = WW'(cnt_q);
  assign pos_w    = WW'(position_i);
  assign cnt_m1   = cnt_q - CW'(1);
  assign full_now = (cnt_w >= lim);

  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.rd_en = 1'b0;
    ctrl.value = value_i;
    cell_pos   = CW'(position_i);
    cell_hi    = cnt_q;
    rd_idx     = CW'(position_i);
    status_d   = ST_OK;
    cnt_d      = cnt_q;
    case (cmd_i)
      CMD_INSERT_AT: begin
        if (pos_w > cnt_w) begin
          status_d = ST_BAD_IDX;
        end else if (full_now) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op = OP_INSERT;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      CMD_APPEND: begin
        cell_pos = cnt_q;
        if (full_now) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op = OP_INSERT;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      CMD_REMOVE_AT: begin
        cell_hi = cnt_m1;
        if (pos_w >= cnt_w) begin
          status_d = ST_BAD_IDX;
        end else begin
          ctrl.op = OP_REMOVE;
          cnt_d   = cnt_m1;
        end
      end
      CMD_REMOVE_LAST: begin
        cell_pos = cnt_m1;
        cell_hi  = cnt_m1;
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.op = OP_REMOVE;
          cnt_d   = cnt_m1;
        end
      end
      CMD_READ_AT: begin
        if (pos_w >= cnt_w) begin
          status_d = ST_BAD_IDX;
        end else begin
          ctrl.rd_en = 1'b1;
        end
      end
      CMD_READ_LAST: begin
        rd_idx = cnt_m1;
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.rd_en = 1'b1;
        end
      end
      CMD_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
    // Nothing moves unless a command is accepted this cycle.
    if (!accept) begin
      ctrl.op    = OP_HOLD;
      ctrl.rd_en = 1'b0;
    end
  end

  // Row of cells, each one handed its neighbors' entries.
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic signed [DATA_W-1:0] tap   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = entry[i+1];
    end
    bilist_cell #(
      .IDX_W (CW),
      .INDEX (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .pos_i    (cell_pos),
      .hi_i     (cell_hi),
      .rd_idx_i (rd_idx),
      .left_i   (left_d),
      .right_i  (right_d),
      .data_o   (entry[i]),
      .tap_o    (tap[i])
    );
  end

  // Combine the read taps; at most one cell drives a nonzero value.
  logic signed [DATA_W-1:0] rd_val;
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | tap[i];
    end
  end

  // Count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= accept;
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_o     <= status_d;
      read_value_o <= rd_val;
      count_o      <= LIMIT_W'(cnt_d);
      is_full_o    <= (WW'(cnt_d) >= lim);
      is_empty_o   <= (cnt_d == '0);
    end
  end

  // The count can never pass the size of the store.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(cnt_q) <= CAP_W)
    else $error("entry count exceeds the store size");

  // Every accepted request gives exactly one result in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted request gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without an accepted request");

  // The reported empty flag agrees with the stored count.
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (cnt_q == '0)))
    else $error("empty flag disagrees with the count");

  // A clear leaves the list empty.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_CLEAR)) |=> (cnt_q == '0))
    else $error("clear did not empty the list");

endmodule

// ----- verif/bounded_insert_remove_list_core_tb.sv -----
module bounded_insert_remove_list_core_tb;
  import bilist_pkg::*;

  localparam int unsigned LIST_DEPTH     = 64;
  localparam logic [2:0]  CMD_UNUSED     = 3'd7;
  localparam logic [2:0]  CAP_LIMIT_ADDR = {REG_CAP_LIMIT, 2'b00};
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_REQUESTS = 65;

  // One result of the list, as predicted.
  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         count;
    logic               is_full;
    logic               is_empty;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         cmd_i = '0;
  logic [5:0]         position_i = '0;
  logic signed [31:0] value_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] read_value_o;
  logic [6:0]         count_o;
  logic               is_full_o;
  logic               is_empty_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predicted contents of the list and the capacity register.
  logic signed [31:0] list_entries[$];
  logic [6:0]         limit_reg = 7'd64;
  list_result_t       pending_results[$];

  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned limits_written = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;

  bounded_insert_remove_list_core #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_value_o(read_value_o),
    .count_o     (count_o),
    .is_full_o   (is_full_o),
    .is_empty_o  (is_empty_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the predicted list and returns its result.
  function automatic list_result_t predict_list_result(logic [2:0] cmd, logic [5:0] pos,
                                                       logic signed [31:0] val);
    list_result_t res;
    int unsigned  lim;
    int unsigned  size;
    lim = (limit_reg == 0) ? 1 : limit_reg;
    if (lim > LIST_DEPTH) lim = LIST_DEPTH;
    size = list_entries.size();
    res.status = ST_OK;
    res.read_value = '0;
    case (cmd)
      CMD_INSERT_AT: begin
        if (pos > size) res.status = ST_BAD_IDX;
        else if (size >= lim) res.status = ST_FULL;
        else list_entries.insert(pos, val);
      end
      CMD_APPEND: begin
        if (size >= lim) res.status = ST_FULL;
        else list_entries.push_back(val);
      end
      CMD_REMOVE_AT: begin
        if (pos >= size) res.status = ST_BAD_IDX;
        else list_entries.delete(pos);
      end
      CMD_REMOVE_LAST: begin
        if (size == 0) res.status = ST_EMPTY;
        else void'(list_entries.pop_back());
      end
      CMD_READ_AT: begin
        if (pos >= size) res.status = ST_BAD_IDX;
        else res.read_value = list_entries[pos];
      end
      CMD_READ_LAST: begin
        if (size == 0) res.status = ST_EMPTY;
        else res.read_value = list_entries[size-1];
      end
      CMD_CLEAR: begin
        list_entries.delete();
      end
      default: begin
      end
    endcase
    size = list_entries.size();
    res.count = size[6:0];
    res.is_full = (size >= lim);
    res.is_empty = (size == 0);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Sends one request, records its prediction once accepted, then idles for a random gap, which may be none.
  task automatic send_request(input logic [2:0] cmd, input logic [5:0] pos,
                              input logic signed [31:0] val);
    int unsigned gap;
    start_i <= 1'b1;
    cmd_i <= cmd;
    position_i <= pos;
    value_i <= val;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_list_result(cmd, pos, val));
    requests_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds requests off until every predicted result has been seen.
  task automatic wait_results_done();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Reads the capacity register back and compares it with the predicted value.
  task automatic check_limit_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAP_LIMIT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[6:0] !== limit_reg) begin
      $error("capacity_limit readback: expected %0d, actual %0d", limit_reg, prdata[6:0]);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the capacity register, with random bits above the field, then reads it back.
  task automatic write_limit(input logic [6:0] lim);
    logic [31:0] word;
    word = $urandom();
    word[6:0] = lim;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_LIMIT_ADDR;
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_reg = lim;
    limits_written++;
    check_limit_readback();
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Compares each strobed result with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    list_result_t exp_r;
    if (rst_ni && done_o) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: status %0d count %0d", status_o, count_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", exp_r.status, status_o);
        check_field("read_value", exp_r.read_value, read_value_o);
        check_field("count", exp_r.count, count_o);
        check_field("is_full", exp_r.is_full, is_full_o);
        check_field("is_empty", exp_r.is_empty, is_empty_o);
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", STALL_LIMIT);
      $display("bounded_insert_remove_list_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Every command, the field extremes and the bad-index and empty error answers on a short list.
  task automatic test_directed_commands();
    send_request(CMD_READ_LAST, 6'd0, 32'sd0);
    send_request(CMD_REMOVE_LAST, 6'd0, 32'sd0);
    send_request(CMD_REMOVE_AT, 6'd0, 32'sd0);
    send_request(CMD_READ_AT, 6'd63, 32'sd0);
    send_request(CMD_INSERT_AT, 6'd1, 32'sd7);
    send_request(CMD_UNUSED, 6'd63, 32'shffff_ffff);
    send_request(CMD_INSERT_AT, 6'd0, 32'sh7fff_ffff);
    send_request(CMD_APPEND, 6'd63, 32'sh8000_0000);
    send_request(CMD_INSERT_AT, 6'd2, 32'sd0);
    send_request(CMD_INSERT_AT, 6'd1, 32'shffff_ffff);
    send_request(CMD_INSERT_AT, 6'd5, 32'sd3);
    send_request(CMD_READ_AT, 6'd0, 32'sd0);
    send_request(CMD_READ_AT, 6'd3, 32'sd0);
    send_request(CMD_READ_AT, 6'd4, 32'sd0);
    send_request(CMD_READ_LAST, 6'd0, 32'sd0);
    send_request(CMD_REMOVE_AT, 6'd1, 32'sd0);
    send_request(CMD_REMOVE_AT, 6'd3, 32'sd0);
    send_request(CMD_REMOVE_LAST, 6'd0, 32'sd0);
    send_request(CMD_READ_AT, 6'd63, 32'sd0);
    send_request(CMD_UNUSED, 6'd0, $urandom());
    send_request(CMD_CLEAR, 6'd0, 32'sd0);
    send_request(CMD_READ_LAST, 6'd0, 32'sd0);
    send_request(CMD_APPEND, 6'd0, 32'sh5a5a_a5a5);
    send_request(CMD_READ_AT, 6'd0, 32'sd0);
  endtask

  // Limits at and beyond both ends, a full store, and a limit dropped below the count.
  task automatic test_capacity_limit();
    int unsigned i;
    wait_results_done();
    check_limit_readback();
    write_limit(7'd1);
    send_request(CMD_CLEAR, 6'd0, 32'sd0);
    send_request(CMD_APPEND, 6'd0, 32'sd11);
    send_request(CMD_APPEND, 6'd0, 32'sd12);
    send_request(CMD_INSERT_AT, 6'd0, 32'sd13);
    send_request(CMD_INSERT_AT, 6'd2, 32'sd14);
    send_request(CMD_READ_LAST, 6'd0, 32'sd0);
    wait_results_done();
    write_limit(7'd0);
    send_request(CMD_APPEND, 6'd0, 32'sd21);
    send_request(CMD_REMOVE_LAST, 6'd0, 32'sd0);
    send_request(CMD_APPEND, 6'd0, 32'sd22);
    wait_results_done();
    write_limit(7'd127);
    send_request(CMD_CLEAR, 6'd0, 32'sd0);
    for (i = 0; i < LIST_DEPTH; i++) send_request(CMD_APPEND, 6'd0, pick_value());
    send_request(CMD_APPEND, 6'd0, 32'sd31);
    send_request(CMD_INSERT_AT, 6'd63, 32'sd32);
    send_request(CMD_READ_AT, 6'd63, 32'sd0);
    send_request(CMD_REMOVE_AT, 6'd63, 32'sd0);
    send_request(CMD_READ_LAST, 6'd0, 32'sd0);
    wait_results_done();
    write_limit(7'd3);
    send_request(CMD_APPEND, 6'd0, 32'sd41);
    send_request(CMD_INSERT_AT, 6'd0, 32'sd42);
    send_request(CMD_REMOVE_AT, 6'd0, 32'sd0);
    send_request(CMD_READ_AT, 6'd0, 32'sd0);
    wait_results_done();
    write_limit(7'd65);
    send_request(CMD_APPEND, 6'd0, 32'sd51);
    send_request(CMD_READ_LAST, 6'd0, 32'sd0);
    wait_results_done();
    write_limit(7'd64);
  endtask

  // Random commands that steer the list toward a drifting fill level.
  task automatic test_random_traffic();
    int unsigned        phase;
    int unsigned        n;
    int unsigned        fill_goal;
    int unsigned        r;
    int unsigned        size;
    int unsigned        raw_pos;
    bit                 grow;
    logic [2:0]         cmd;
    logic [5:0]         pos;
    logic [6:0]         lim;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_results_done();
      r = $urandom_range(9);
      if (r < 7) lim = 7'($urandom_range(64, 1));
      else if (r == 7) lim = 7'd0;
      else lim = 7'($urandom_range(127, 65));
      write_limit(lim);
      fill_goal = $urandom_range(LIST_DEPTH);
      gaps_on = (phase != 2);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        // Now and then let every outstanding result come back first.
        if ($urandom_range(99) < 2) wait_results_done();
        if ($urandom_range(99) < 3) fill_goal = $urandom_range(LIST_DEPTH);
        if (phase != 2 && n % 20 == 0) gaps_on = ($urandom_range(3) != 0);
        size = list_entries.size();
        grow = (size < fill_goal);
        if ($urandom_range(99) < 15) grow = !grow;
        r = $urandom_range(99);
        if (r < 2) cmd = CMD_CLEAR;
        else if (r < 4) cmd = CMD_UNUSED;
        else if (r < 20) cmd = CMD_READ_AT;
        else if (r < 28) cmd = CMD_READ_LAST;
        else if (r < 64) cmd = grow ? CMD_INSERT_AT : CMD_REMOVE_AT;
        else cmd = grow ? CMD_APPEND : CMD_REMOVE_LAST;
        raw_pos = ($urandom_range(99) < 85) ? $urandom_range(size) : $urandom_range(63);
        pos = (raw_pos > 63) ? 6'd63 : raw_pos[5:0];
        send_request(cmd, pos, pick_value());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_commands();
    test_capacity_limit();
    test_random_traffic();
    wait_results_done();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results across %0d capacity settings,",
             requests_sent, results_checked, limits_written);
    $display("covering every command, error status, full list and out-of-range limits.");
    if (error_count == 0) begin
      $display("bounded_insert_remove_list_core test passed");
    end else begin
      $display("bounded_insert_remove_list_core test failed");
    end
    $finish;
  end

endmodule
